>>> src/ccrn_pkg.sv
package ccrn_pkg;

  localparam int MAX_CHANNELS_DEF = 64;
  localparam int SUM_W = 36;

  localparam logic [1:0] CFG_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_BETA   = 2'd1;
  localparam logic [1:0] CFG_K      = 2'd2;
  localparam logic [1:0] CFG_WINDOW = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_channel;
  } in_t;

  typedef struct packed {
    logic signed [15:0] norm_value;
    logic               last_out;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [23:0] alpha_scale;
    logic [15:0] beta_power;
    logic [15:0] k_bias;
    logic [5:0]  window_size;
  } cfg_t;

  typedef logic [15:0][31:0] rom_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int q = 0; q < 32; q++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // c[j] = sqrt(c[j-1]) in Q1.30, starting from 2.0
  function automatic rom_t build_roots();
    rom_t        r;
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 0; j < 16; j++) begin
      c    = isqrt64(c << 30);
      r[j] = c[31:0];
    end
    return r;
  endfunction

  localparam rom_t ROOT_ROM = build_roots();

endpackage

>>> src/cross_channel_response_norm.sv
// Cross-channel response normalization, one pixel at a time.
// Input channel: in_valid/in_ready carry one channel value (signed Q8.8)
// per request; last_channel marks the end of the pixel. Channels past
// MAX_CHANNELS are dropped and every result of that pixel has overflow set.
// Non-last requests are only stored in the buffer and produce nothing.
// After the last request the block stops taking input and emits one result
// per buffered channel, in order, on out_valid/out_ready; last_out marks the
// final one. Each result sums squares over its taps (taps = channels in
// the clipped window, at most 2*floor(window_size/2)+1); a zero sample or a
// zero base skips log2 and exp2. Each tap reads the channel buffer and then
// accumulates; log2 normalizes by shifts and then does 16 squarings
// and exp2 takes 16 root multiplies, all on one shared 32x32 multiplier.
// in_ready returns in the cycle in which the last result of the pixel
// first shows on out_valid.
// A stalled receiver holds the finished result in the output register and
// the sequencer waits on it; nothing is lost.
// Config is a plain write port (cfg_we/cfg_addr/cfg_wdata); the user must
// write it only while idle, the block does not check. Synchronous active-low
// reset restores defaults and clears channel count, drop flag and out_valid.
module cross_channel_response_norm #(
  parameter int MAX_CHANNELS = ccrn_pkg::MAX_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ccrn_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ccrn_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [23:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_CHANNELS);
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  ccrn_pkg::cfg_t      cfg_r, cfg_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                drop_r, drop_nxt;

  logic                accept;
  logic                has_room;
  logic                busy;
  logic                start;
  logic [CNT_W-1:0]    start_n;
  logic                start_ovf;
  logic [IDX_W-1:0]    rd_addr;
  logic signed [15:0]  rd_data;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !busy;
  assign has_room  = (count_r < CNT_W'(MAX_CHANNELS));
  assign start     = accept && in_data.last_channel;
  assign start_n   = has_room ? count_r + CNT_W'(1) : count_r;
  assign start_ovf = drop_r || !has_room;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ccrn_pkg::CFG_ALPHA:  cfg_nxt.alpha_scale = cfg_wdata;
        ccrn_pkg::CFG_BETA:   cfg_nxt.beta_power  = cfg_wdata[15:0];
        ccrn_pkg::CFG_K:      cfg_nxt.k_bias      = cfg_wdata[15:0];
        ccrn_pkg::CFG_WINDOW: cfg_nxt.window_size = cfg_wdata[5:0];
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (accept) begin
      if (in_data.last_channel) begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end else if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_scale <= 24'd1678;
      cfg_r.beta_power  <= 16'd12288;
      cfg_r.k_bias      <= 16'd512;
      cfg_r.window_size <= 6'd5;
      count_r           <= '0;
      drop_r            <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  ccrn_buf #(
    .DEPTH(MAX_CHANNELS),
    .AW   (IDX_W)
  ) u_buf (
    .clk  (clk),
    .we   (accept && has_room),
    .waddr(IDX_W'(count_r)),
    .wdata(in_data.sample),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  ccrn_seq #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (start),
    .start_n  (start_n),
    .start_ovf(start_ovf),
    .busy     (busy),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> src/ccrn_mul.sv
module ccrn_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  assign p = {32'b0, a} * {32'b0, b};

endmodule

>>> src/ccrn_buf.sv
module ccrn_buf #(
  parameter int DEPTH = ccrn_pkg::MAX_CHANNELS_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [15:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [15:0]  rdata
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ccrn_seq.sv
module ccrn_seq #(
  parameter int MAX_CHANNELS = ccrn_pkg::MAX_CHANNELS_DEF,
  parameter int IDX_W = $clog2(MAX_CHANNELS),
  parameter int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ccrn_pkg::cfg_t      cfg,
  input  logic                start,
  input  logic [CNT_W-1:0]    start_n,
  input  logic                start_ovf,
  output logic                busy,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic signed [15:0]  rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccrn_pkg::out_t      out_data
);

  localparam int EXT_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XRD  = 4'd1;
  localparam logic [3:0] S_XGET = 4'd2;
  localparam logic [3:0] S_TRD  = 4'd3;
  localparam logic [3:0] S_TACC = 4'd4;
  localparam logic [3:0] S_MLO  = 4'd5;
  localparam logic [3:0] S_MHI  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_NORM = 4'd8;
  localparam logic [3:0] S_SQR  = 4'd9;
  localparam logic [3:0] S_EXPN = 4'd10;
  localparam logic [3:0] S_EXP  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_RND  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [IDX_W-1:0]        addr_r, addr_nxt;
  logic [IDX_W-1:0]        t_r, t_nxt;
  logic [IDX_W-1:0]        hi_r, hi_nxt;
  logic signed [15:0]      x_r, x_nxt;
  logic [ccrn_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [63:0]             base_r, base_nxt;
  logic [63:0]             w_r, w_nxt;
  logic [5:0]              p_r, p_nxt;
  logic [30:0]             m_r, m_nxt;
  logic [15:0]             frac_r, frac_nxt;
  logic [3:0]              k_r, k_nxt;
  logic signed [7:0]       ip_r, ip_nxt;
  logic [15:0]             fr_r, fr_nxt;
  logic [31:0]             g_r, g_nxt;
  logic [47:0]             prod_r, prod_nxt;
  logic [15:0]             res_r, res_nxt;
  ccrn_pkg::out_t          out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [31:0]             mul_a, mul_b;
  logic [63:0]             mul_p;

  logic [15:0]             rd_mag, x_mag;
  logic [EXT_W-1:0]        i_ext, h_ext, lo_ext, hi_ext, nm1_ext;
  logic signed [23:0]      lg;
  logic [23:0]             lg_mag;
  logic signed [39:0]      e_val, e16, n_val;
  logic signed [39:0]      ip_full;
  logic [31:0]             sq;
  logic signed [7:0]       sh;
  logic [64:0]             q;

  ccrn_mul u_mul (
    .a(mul_a),
    .b(mul_b),
    .p(mul_p)
  );

  assign rd_mag  = rd_data[15] ? 16'(-rd_data) : 16'(rd_data);
  assign x_mag   = x_r[15] ? 16'(-x_r) : 16'(x_r);
  assign lg      = {8'($signed({2'b00, p_r}) - 8'sd40), frac_r};
  assign lg_mag  = lg[23] ? 24'(-lg) : 24'(lg);
  assign sq      = mul_p[61:30];
  assign sh      = 8'sd30 - ip_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TACC: begin
        mul_a = {16'b0, rd_mag};
        mul_b = {16'b0, rd_mag};
      end
      S_MLO: begin
        mul_a = {8'b0, cfg.alpha_scale};
        mul_b = sum_r[31:0];
      end
      S_MHI: begin
        mul_a = {8'b0, cfg.alpha_scale};
        mul_b = {28'b0, sum_r[ccrn_pkg::SUM_W-1:32]};
      end
      S_SQR: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      S_EXPN: begin
        mul_a = {8'b0, lg_mag};
        mul_b = {16'b0, cfg.beta_power};
      end
      S_EXP: begin
        mul_a = g_r;
        mul_b = ccrn_pkg::ROOT_ROM[k_r];
      end
      S_FIN: begin
        mul_a = {16'b0, x_mag};
        mul_b = g_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    i_ext   = EXT_W'(i_r);
    h_ext   = EXT_W'(cfg.window_size[5:1]);
    nm1_ext = EXT_W'(n_r) - EXT_W'(1);
    lo_ext  = (i_ext > h_ext) ? (i_ext - h_ext) : '0;
    hi_ext  = i_ext + h_ext;
    if (hi_ext > nm1_ext) begin
      hi_ext = nm1_ext;
    end
  end

  // floor shifts; n = -E split into integer and 16-bit fraction
  always_comb begin
    e_val   = lg[23] ? -$signed({1'b0, mul_p[38:0]}) : $signed({1'b0, mul_p[38:0]});
    e16     = e_val >>> 14;
    n_val   = -e16;
    ip_full = n_val >>> 16;
  end

  always_comb begin
    q = '0;
    if (sh >= 8'sd48) begin
      q = '0;
    end else if (sh > 8'sd0) begin
      q = ({17'b0, prod_r} + (65'd1 << 6'(sh - 8'sd1))) >> 6'(sh);
    end else if (sh <= -8'sd17) begin
      q = 65'd1 << 40;
    end else begin
      q = {17'b0, prod_r} << 5'(-sh);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    addr_nxt      = addr_r;
    t_nxt         = t_r;
    hi_nxt        = hi_r;
    x_nxt         = x_r;
    sum_nxt       = sum_r;
    base_nxt      = base_r;
    w_nxt         = w_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    frac_nxt      = frac_r;
    k_nxt         = k_r;
    ip_nxt        = ip_r;
    fr_nxt        = fr_r;
    g_nxt         = g_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt     = start_n;
          ovf_nxt   = start_ovf;
          i_nxt     = '0;
          addr_nxt  = '0;
          state_nxt = S_XRD;
        end
      end
      S_XRD: state_nxt = S_XGET;
      S_XGET: begin
        x_nxt     = rd_data;
        t_nxt     = IDX_W'(lo_ext);
        addr_nxt  = IDX_W'(lo_ext);
        hi_nxt    = IDX_W'(hi_ext);
        sum_nxt   = '0;
        state_nxt = S_TRD;
      end
      S_TRD: state_nxt = S_TACC;
      S_TACC: begin
        sum_nxt = sum_r + ccrn_pkg::SUM_W'(mul_p[31:0]);
        if (t_r == hi_r) begin
          state_nxt = S_MLO;
        end else begin
          t_nxt     = t_r + IDX_W'(1);
          addr_nxt  = t_r + IDX_W'(1);
          state_nxt = S_TRD;
        end
      end
      S_MLO: begin
        base_nxt  = mul_p + {16'b0, cfg.k_bias, 32'b0};
        state_nxt = S_MHI;
      end
      S_MHI: begin
        base_nxt  = base_r + {mul_p[31:0], 32'b0};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        priority if (x_r == 16'sd0) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else if (base_r == '0) begin
          if (cfg.beta_power == '0) begin
            res_nxt = x_r;
          end else begin
            res_nxt = x_r[15] ? 16'h8000 : 16'h7fff;
          end
          state_nxt = S_OUT;
        end else begin
          w_nxt     = base_r;
          p_nxt     = 6'd63;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        priority if (w_r[63]) begin
          m_nxt     = w_r[63:33];
          frac_nxt  = '0;
          k_nxt     = '0;
          state_nxt = S_SQR;
        end else if (w_r[63:48] == '0) begin
          w_nxt = w_r << 16;
          p_nxt = p_r - 6'd16;
        end else if (w_r[63:60] == '0) begin
          w_nxt = w_r << 4;
          p_nxt = p_r - 6'd4;
        end else begin
          w_nxt = w_r << 1;
          p_nxt = p_r - 6'd1;
        end
      end
      S_SQR: begin
        if (sq[31]) begin
          m_nxt    = sq[31:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          m_nxt    = sq[30:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd15) begin
          state_nxt = S_EXPN;
        end
      end
      S_EXPN: begin
        if (ip_full > 40'sd64) begin
          ip_nxt = 8'sd64;
        end else if (ip_full < -40'sd64) begin
          ip_nxt = -8'sd64;
        end else begin
          ip_nxt = 8'(ip_full);
        end
        fr_nxt    = n_val[15:0];
        g_nxt     = 32'd1 << 30;
        k_nxt     = '0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        if (fr_r[4'd15 - k_r]) begin
          g_nxt = mul_p[61:30];
        end
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd15) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        prod_nxt  = mul_p[47:0];
        state_nxt = S_RND;
      end
      S_RND: begin
        if (!x_r[15]) begin
          res_nxt = (q > 65'd32767) ? 16'h7fff : q[15:0];
        end else begin
          res_nxt = (q > 65'd32768) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.norm_value = res_r;
          out_nxt.last_out   = (CNT_W'(i_r) == n_r - CNT_W'(1));
          out_nxt.overflow   = ovf_r;
          out_valid_nxt      = 1'b1;
          if (CNT_W'(i_r) == n_r - CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            addr_nxt  = i_r + IDX_W'(1);
            state_nxt = S_XRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    ovf_r  <= ovf_nxt;
    addr_r <= addr_nxt;
    t_r    <= t_nxt;
    hi_r   <= hi_nxt;
    x_r    <= x_nxt;
    sum_r  <= sum_nxt;
    base_r <= base_nxt;
    w_r    <= w_nxt;
    p_r    <= p_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
    ip_r   <= ip_nxt;
    fr_r   <= fr_nxt;
    g_r    <= g_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign rd_addr   = addr_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("start while busy");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> CNT_W'(i_r) < n_r)
    else $error("channel index past count");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NORM |-> w_r != '0)
    else $error("normalize on zero base");

  a_tap_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TACC |-> t_r <= hi_r && CNT_W'(hi_r) < n_r)
    else $error("tap outside window");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt == S_IDLE) |=> out_valid_r && out_r.last_out)
    else $error("final request not flagged last");

endmodule
